[src/stvg_pkg.sv]
// Shared types, constants and helpers of the sphere tile vertex generator.
`timescale 1ns / 1ps
package stvg_pkg;

	localparam int IDX_W   = 8;
	localparam int CNT_W   = 8;
	localparam int ANGLE_W = 16;
	localparam int COORD_W = 16;
	localparam int ROM_W   = 15;

	localparam int SINE_TABLE_DEPTH_DEF = 256;
	localparam int MAX_DIVISIONS        = 255;

	localparam logic [CNT_W-1:0] MIN_RINGS    = 8'd2;
	localparam logic [CNT_W-1:0] MIN_SEGMENTS = 8'd3;

	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_RING_COUNT    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_COUNT = 8'd1;

	// reciprocal of the doubled count, scaled by 2^RECIP_SHIFT
	localparam int RECIP_SHIFT = 25;
	localparam int RECIP_W     = 24;
	localparam int DIV_W       = CNT_W + 1;
	localparam int NUM_W       = 25;
	localparam int QUO_W       = 17;

	localparam logic [RECIP_W-1:0] RECIP_PHI_RST =
		RECIP_W'((64'd1 << RECIP_SHIFT) / (2 * 2));
	localparam logic [RECIP_W-1:0] RECIP_THETA_RST =
		RECIP_W'((64'd1 << RECIP_SHIFT) / (2 * 3));

	localparam logic [63:0] PI_Q30 = 64'd3373259426;
	localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;

	// vertex order TL, BL, BR, TR, TL, BR; bit k belongs to vertex k
	localparam int VTX_PER_TILE = 6;
	localparam int VTX_CNT_W    = 3;
	localparam logic [VTX_PER_TILE-1:0] CORNER_BOT   = 6'b100110;
	localparam logic [VTX_PER_TILE-1:0] CORNER_RIGHT = 6'b101100;
	localparam logic [VTX_CNT_W-1:0] LAST_VTX = 3'd5;

	typedef struct packed {
		logic [IDX_W-1:0] ring_index;
		logic [IDX_W-1:0] segment_index;
	} tile_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic signed [COORD_W-1:0] norm_x;
		logic signed [COORD_W-1:0] norm_y;
		logic signed [COORD_W-1:0] norm_z;
		logic                      last_vertex;
	} vertex_t;

	typedef struct packed {
		logic [CNT_W-1:0]   rings;
		logic [CNT_W-1:0]   segments;
		logic [RECIP_W-1:0] recip_phi;
		logic [RECIP_W-1:0] recip_theta;
	} cfg_t;

	typedef struct packed {
		logic [IDX_W-1:0] phi_k;
		logic [IDX_W-1:0] theta_k;
		logic             last;
	} vtx_req_t;

	typedef enum logic {
		SEQ_IDLE,
		SEQ_ISSUE
	} seq_state_t;

	typedef enum logic {
		DIV_IDLE,
		DIV_RUN
	} div_state_t;

	function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] value,
		input logic [CNT_W-1:0] floor_v);
		logic [CNT_W-1:0] r;
		r = value;
		if (value < floor_v) begin
			r = floor_v;
		end
		if (r > CNT_W'(MAX_DIVISIONS)) begin
			r = CNT_W'(MAX_DIVISIONS);
		end
		return r;
	endfunction

endpackage

[src/stvg_recip_div.sv]
// Bit-serial divider that forms 2^RECIP_SHIFT / divisor after a count write.
`timescale 1ns / 1ps
module stvg_recip_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [stvg_pkg::DIV_W-1:0]    divisor,
	output logic                          busy,
	output logic                          done,
	output logic [stvg_pkg::RECIP_W-1:0]  quotient
);

	localparam int STEPS  = stvg_pkg::RECIP_SHIFT + 1;
	localparam int STEP_W = $clog2(STEPS);

	stvg_pkg::div_state_t state_q, state_nx;
	logic [STEP_W-1:0]            step_q;
	logic                         done_q;
	logic [stvg_pkg::DIV_W-1:0]   dvs_q;
	logic [stvg_pkg::DIV_W-1:0]   rem_q;
	logic [stvg_pkg::RECIP_W-1:0] quo_q;

	logic                         num_bit;
	logic [stvg_pkg::DIV_W:0]     rem_sh;
	logic                         ge;
	logic [stvg_pkg::DIV_W:0]     rem_diff;
	logic [stvg_pkg::DIV_W-1:0]   rem_nx;

	// the dividend is a single one at bit RECIP_SHIFT
	assign num_bit  = (step_q == STEP_W'(stvg_pkg::RECIP_SHIFT));
	assign rem_sh   = {rem_q, num_bit};
	assign ge       = (rem_sh >= {1'b0, dvs_q});
	assign rem_diff = rem_sh - {1'b0, dvs_q};
	assign rem_nx   = ge ? rem_diff[stvg_pkg::DIV_W-1:0] : rem_sh[stvg_pkg::DIV_W-1:0];

	always_comb begin
		state_nx = state_q;
		case (state_q)
			stvg_pkg::DIV_IDLE: begin
				if (start) begin
					state_nx = stvg_pkg::DIV_RUN;
				end
			end
			stvg_pkg::DIV_RUN: begin
				if (step_q == '0) begin
					state_nx = stvg_pkg::DIV_IDLE;
				end
			end
			default: state_nx = stvg_pkg::DIV_IDLE;
		endcase
	end

	always_comb begin
		busy     = (state_q == stvg_pkg::DIV_RUN) || done_q;
		done     = done_q;
		quotient = quo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stvg_pkg::DIV_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			done_q  <= (state_q == stvg_pkg::DIV_RUN) && (step_q == '0);
			if (state_q == stvg_pkg::DIV_IDLE && start) begin
				step_q <= STEP_W'(stvg_pkg::RECIP_SHIFT);
			end else if (state_q == stvg_pkg::DIV_RUN && step_q != '0) begin
				step_q <= step_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == stvg_pkg::DIV_IDLE && start) begin
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (state_q == stvg_pkg::DIV_RUN) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[stvg_pkg::RECIP_W-2:0], ge};
		end
	end

endmodule

[src/stvg_sine_rom.sv]
// Quarter-wave sine table, entries built at elaboration by a Q30 series.
`timescale 1ns / 1ps
module stvg_sine_rom #(
	parameter int DEPTH = stvg_pkg::SINE_TABLE_DEPTH_DEF,
	localparam int AW   = $clog2(DEPTH + 1)
) (
	input  logic [AW-1:0]              addr,
	output logic [stvg_pkg::ROM_W-1:0] data
);

	logic [stvg_pkg::ROM_W-1:0] tbl [0:DEPTH];

	for (genvar k = 0; k <= DEPTH; k++) begin : g_ent
		localparam logic [63:0] X  = (64'(k) * stvg_pkg::PI_Q30) / 64'(2 * DEPTH);
		localparam logic [63:0] T1 = ((((X  * X) >> 30) * X) >> 30) / 64'd6;
		localparam logic [63:0] T2 = ((((T1 * X) >> 30) * X) >> 30) / 64'd20;
		localparam logic [63:0] T3 = ((((T2 * X) >> 30) * X) >> 30) / 64'd42;
		localparam logic [63:0] T4 = ((((T3 * X) >> 30) * X) >> 30) / 64'd72;
		localparam logic [63:0] T5 = ((((T4 * X) >> 30) * X) >> 30) / 64'd110;
		localparam logic [63:0] T6 = ((((T5 * X) >> 30) * X) >> 30) / 64'd156;
		localparam logic [63:0] T7 = ((((T6 * X) >> 30) * X) >> 30) / 64'd210;
		localparam logic [63:0] SUM = X - T1 + T2 - T3 + T4 - T5 + T6 - T7;
		localparam logic [63:0] RND = (SUM + 64'd16384) >> 15;
		localparam logic [stvg_pkg::ROM_W-1:0] VAL =
			(RND > 64'd32767) ? 15'h7FFF : RND[stvg_pkg::ROM_W-1:0];
		assign tbl[k] = VAL;
	end

	assign data = tbl[addr];

endmodule

[src/stvg_tile_seq.sv]
// Tile request capture and six-vertex issue sequencer.
`timescale 1ns / 1ps
module stvg_tile_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  stvg_pkg::tile_t     tile_req,
	input  logic                hold,
	input  stvg_pkg::cfg_t      cfg,
	output logic                vtx_valid,
	input  logic                vtx_ready,
	output stvg_pkg::vtx_req_t  vtx
);

	stvg_pkg::seq_state_t state_q, state_nx;
	logic [stvg_pkg::VTX_CNT_W-1:0] cnt_q;
	logic [stvg_pkg::IDX_W-1:0]     ring_q;
	logic [stvg_pkg::IDX_W-1:0]     seg_q;

	logic                           issue_last;
	logic                           accept;
	logic [stvg_pkg::IDX_W-1:0]     ring_max;
	logic [stvg_pkg::IDX_W-1:0]     seg_max;

	assign issue_last = (state_q == stvg_pkg::SEQ_ISSUE) && (cnt_q == stvg_pkg::LAST_VTX)
		&& vtx_ready;
	assign accept     = in_valid && !in_stall;
	assign ring_max   = cfg.rings - 1'b1;
	assign seg_max    = cfg.segments - 1'b1;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			stvg_pkg::SEQ_IDLE: begin
				if (accept) begin
					state_nx = stvg_pkg::SEQ_ISSUE;
				end
			end
			stvg_pkg::SEQ_ISSUE: begin
				if (issue_last && !accept) begin
					state_nx = stvg_pkg::SEQ_IDLE;
				end
			end
			default: state_nx = stvg_pkg::SEQ_IDLE;
		endcase
	end

	// take the next request in the cycle the sixth vertex leaves, unless hold is set
	always_comb begin
		in_stall    = hold || ((state_q == stvg_pkg::SEQ_ISSUE) && !issue_last);
		vtx_valid   = (state_q == stvg_pkg::SEQ_ISSUE);
		vtx.phi_k   = ring_q + stvg_pkg::IDX_W'(stvg_pkg::CORNER_BOT[cnt_q]);
		vtx.theta_k = seg_q + stvg_pkg::IDX_W'(stvg_pkg::CORNER_RIGHT[cnt_q]);
		vtx.last    = (cnt_q == stvg_pkg::LAST_VTX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stvg_pkg::SEQ_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				cnt_q <= '0;
			end else if (state_q == stvg_pkg::SEQ_ISSUE && vtx_ready) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// saturate out-of-range indices on capture
	always_ff @(posedge clk) begin
		if (accept) begin
			ring_q <= (tile_req.ring_index > ring_max) ? ring_max : tile_req.ring_index;
			seg_q  <= (tile_req.segment_index > seg_max) ? seg_max : tile_req.segment_index;
		end
	end

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == stvg_pkg::SEQ_ISSUE) |-> (ring_q < cfg.rings && seg_q < cfg.segments))
		else $error("captured tile index beyond the configured count");

endmodule

[src/stvg_vertex_pipe.sv]
// Seven-stage vertex pipeline: angles, sine lookup, products and rounding.
`timescale 1ns / 1ps
module stvg_vertex_pipe #(
	parameter int SINE_TABLE_DEPTH = stvg_pkg::SINE_TABLE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  stvg_pkg::cfg_t      cfg,
	input  logic                req_valid,
	output logic                req_ready,
	input  stvg_pkg::vtx_req_t  req,
	output logic                out_valid,
	input  logic                out_stall,
	output stvg_pkg::vertex_t   vertex
);

	localparam int AW     = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int LP_W   = 15 + AW;
	localparam int PROD_W = stvg_pkg::NUM_W + stvg_pkg::RECIP_W;
	localparam int REM_W  = stvg_pkg::QUO_W + stvg_pkg::DIV_W;
	localparam int LANES  = 4;
	localparam int LANE_SP = 0;
	localparam int LANE_CP = 1;
	localparam int LANE_ST = 2;
	localparam int LANE_CT = 3;
	localparam int ROM_SHIFT = 14;
	localparam logic [14:0] QUARTER_OFF = 15'h4000;
	localparam logic signed [31:0] Y_SCALE = 32'sd32768;

	function automatic logic signed [stvg_pkg::COORD_W-1:0] round_q15(
		input logic signed [31:0] p);
		logic signed [32:0] s;
		s = {p[31], p} + 33'sd32768;
		return s[31:16];
	endfunction

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;
	logic last_s1, last_s2, last_s3, last_s4, last_s5, last_s6;

	logic [stvg_pkg::NUM_W-1:0]   n_phi_s1, n_th_s1, n_phi_s2, n_th_s2;
	logic [stvg_pkg::QUO_W-1:0]   q0_phi_s2, q0_th_s2;
	logic [stvg_pkg::ANGLE_W-1:0] phi_s3, theta_s3;
	logic [AW-1:0]                idx_s4 [LANES];
	logic                         neg_s4 [LANES];
	logic signed [stvg_pkg::COORD_W-1:0] val_s5 [LANES];
	logic signed [31:0]           x_p_s6, y_p_s6, z_p_s6;
	stvg_pkg::vertex_t            vertex_s7;

	logic [PROD_W-1:0]            prod_phi, prod_th;
	logic [stvg_pkg::DIV_W-1:0]   d_phi, d_th;
	logic [REM_W-1:0]             rem_phi, rem_th;
	logic [stvg_pkg::QUO_W-1:0]   q_phi, q_th;
	logic [stvg_pkg::ANGLE_W-1:0] ang [LANES];
	logic [AW-1:0]                idx_nx [LANES];
	logic                         neg_nx [LANES];
	logic [stvg_pkg::ROM_W-1:0]   rom_data [LANES];

	// a stage takes new data when it is empty or its contents move on
	assign rdy7 = !v_s7 || !out_stall;
	assign rdy6 = !v_s6 || rdy7;
	assign rdy5 = !v_s5 || rdy6;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign req_ready = rdy1;

	// reciprocal estimate is low by at most one; fix with the remainder
	always_comb begin
		prod_phi = PROD_W'(n_phi_s1) * PROD_W'(cfg.recip_phi);
		prod_th  = PROD_W'(n_th_s1) * PROD_W'(cfg.recip_theta);
		d_phi    = {cfg.rings, 1'b0};
		d_th     = {cfg.segments, 1'b0};
		rem_phi  = REM_W'(n_phi_s2) - REM_W'(q0_phi_s2) * REM_W'(d_phi);
		rem_th   = REM_W'(n_th_s2) - REM_W'(q0_th_s2) * REM_W'(d_th);
		q_phi    = q0_phi_s2 + stvg_pkg::QUO_W'(rem_phi >= REM_W'(d_phi));
		q_th     = q0_th_s2 + stvg_pkg::QUO_W'(rem_th >= REM_W'(d_th));
	end

	always_comb begin
		logic [1:0]      quad;
		logic [14:0]     r;
		logic [14:0]     off;
		logic [LP_W-1:0] lp;
		ang[LANE_SP] = phi_s3;
		ang[LANE_CP] = phi_s3 + stvg_pkg::QUARTER_TURN;
		ang[LANE_ST] = theta_s3;
		ang[LANE_CT] = theta_s3 + stvg_pkg::QUARTER_TURN;
		for (int l = 0; l < LANES; l++) begin
			quad = ang[l][15:14];
			r    = {1'b0, ang[l][13:0]};
			// mirror the offset in the odd quadrants
			off  = quad[0] ? (QUARTER_OFF - r) : r;
			lp   = LP_W'(off) * LP_W'(SINE_TABLE_DEPTH) + LP_W'(1 << (ROM_SHIFT - 1));
			idx_nx[l] = lp[ROM_SHIFT +: AW];
			neg_nx[l] = quad[1];
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_rom
		stvg_sine_rom #(
			.DEPTH(SINE_TABLE_DEPTH)
		) u_rom (
			.addr(idx_s4[l]),
			.data(rom_data[l])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= req_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
			if (rdy7) v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			n_phi_s1 <= stvg_pkg::NUM_W'({req.phi_k, 16'h0000})
				+ stvg_pkg::NUM_W'(cfg.rings);
			n_th_s1  <= {req.theta_k, 17'h00000} + stvg_pkg::NUM_W'(cfg.segments);
			last_s1  <= req.last;
		end
		if (rdy2) begin
			q0_phi_s2 <= prod_phi[stvg_pkg::RECIP_SHIFT +: stvg_pkg::QUO_W];
			q0_th_s2  <= prod_th[stvg_pkg::RECIP_SHIFT +: stvg_pkg::QUO_W];
			n_phi_s2  <= n_phi_s1;
			n_th_s2   <= n_th_s1;
			last_s2   <= last_s1;
		end
		if (rdy3) begin
			phi_s3   <= q_phi[stvg_pkg::ANGLE_W-1:0];
			// the last slice wraps to zero
			theta_s3 <= q_th[stvg_pkg::ANGLE_W-1:0];
			last_s3  <= last_s2;
		end
		if (rdy4) begin
			for (int l = 0; l < LANES; l++) begin
				idx_s4[l] <= idx_nx[l];
				neg_s4[l] <= neg_nx[l];
			end
			last_s4 <= last_s3;
		end
		if (rdy5) begin
			for (int l = 0; l < LANES; l++) begin
				val_s5[l] <= neg_s4[l] ? -$signed({1'b0, rom_data[l]})
					: $signed({1'b0, rom_data[l]});
			end
			last_s5 <= last_s4;
		end
		if (rdy6) begin
			x_p_s6  <= 32'(val_s5[LANE_SP]) * 32'(val_s5[LANE_ST]);
			y_p_s6  <= 32'(val_s5[LANE_CP]) * Y_SCALE;
			z_p_s6  <= 32'(val_s5[LANE_SP]) * 32'(val_s5[LANE_CT]);
			last_s6 <= last_s5;
		end
		if (rdy7) begin
			vertex_s7.pos_x       <= round_q15(x_p_s6);
			vertex_s7.pos_y       <= round_q15(y_p_s6);
			vertex_s7.pos_z       <= round_q15(z_p_s6);
			vertex_s7.norm_x      <= round_q15(x_p_s6);
			vertex_s7.norm_y      <= round_q15(y_p_s6);
			vertex_s7.norm_z      <= round_q15(z_p_s6);
			vertex_s7.last_vertex <= last_s6;
		end
	end

	assign out_valid = v_s7;
	assign vertex    = vertex_s7;

	a_quotient_fix: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (rem_phi < REM_W'({d_phi, 1'b0}) && rem_th < REM_W'({d_th, 1'b0})))
		else $error("reciprocal estimate off by more than one");

	a_phi_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (phi_s3 <= 16'h8000))
		else $error("polar angle beyond a half turn");

endmodule

[src/sphere_tile_vertex_generator.sv]
// Top level of the UV sphere tile vertex generator.
//
//  channel  | handshake               | payload                      | dir
//  ---------+-------------------------+------------------------------+-----
//  cfg      | cfg_valid / cfg_ready   | cfg_index, cfg_data          | in
//  in       | in_valid / in_stall     | tile_req (ring, segment)     | in
//  out      | out_valid / out_stall   | vertex (pos, norm, last)     | out
//
// The sequencer issues one vertex a cycle, while out is not stalled, into a
// seven-stage pipeline and takes the next tile request as the sixth vertex issues.
// Reset sets 2 rings and 3 segments with their reciprocals preset; no clearing pass.
// A count write starts the bit-serial reciprocal divider: requests and further writes
// wait for its result. A stall on out backs up stage by stage, then holds in.
`timescale 1ns / 1ps
module sphere_tile_vertex_generator #(
	parameter int SINE_TABLE_DEPTH = stvg_pkg::SINE_TABLE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [stvg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [stvg_pkg::CNT_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  stvg_pkg::tile_t                   tile_req,
	output logic                              out_valid,
	input  logic                              out_stall,
	output stvg_pkg::vertex_t                 vertex
);

	logic [stvg_pkg::CNT_W-1:0]   ring_count_q;
	logic [stvg_pkg::CNT_W-1:0]   segment_count_q;
	logic [stvg_pkg::RECIP_W-1:0] recip_phi_q;
	logic [stvg_pkg::RECIP_W-1:0] recip_theta_q;
	logic                         tgt_seg_q;

	stvg_pkg::cfg_t               cfg;
	stvg_pkg::vtx_req_t           vtx;
	logic                         vtx_valid;
	logic                         vtx_ready;
	logic                         cfg_wr;
	logic                         div_start;
	logic                         div_busy;
	logic                         div_done;
	logic [stvg_pkg::DIV_W-1:0]   div_divisor;
	logic [stvg_pkg::RECIP_W-1:0] div_quotient;
	logic [stvg_pkg::CNT_W-1:0]   wr_eff;

	assign cfg_ready = !div_busy;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign div_start = cfg_wr && (cfg_index == stvg_pkg::CFG_RING_COUNT
		|| cfg_index == stvg_pkg::CFG_SEGMENT_COUNT);

	always_comb begin
		if (cfg_index == stvg_pkg::CFG_RING_COUNT) begin
			wr_eff = stvg_pkg::eff_count(cfg_data, stvg_pkg::MIN_RINGS);
		end else begin
			wr_eff = stvg_pkg::eff_count(cfg_data, stvg_pkg::MIN_SEGMENTS);
		end
		div_divisor     = {wr_eff, 1'b0};
		cfg.rings       = stvg_pkg::eff_count(ring_count_q, stvg_pkg::MIN_RINGS);
		cfg.segments    = stvg_pkg::eff_count(segment_count_q, stvg_pkg::MIN_SEGMENTS);
		cfg.recip_phi   = recip_phi_q;
		cfg.recip_theta = recip_theta_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_count_q    <= stvg_pkg::MIN_RINGS;
			segment_count_q <= stvg_pkg::MIN_SEGMENTS;
			recip_phi_q     <= stvg_pkg::RECIP_PHI_RST;
			recip_theta_q   <= stvg_pkg::RECIP_THETA_RST;
			tgt_seg_q       <= 1'b0;
		end else begin
			if (cfg_wr && cfg_index == stvg_pkg::CFG_RING_COUNT) begin
				ring_count_q <= cfg_data;
				tgt_seg_q    <= 1'b0;
			end
			if (cfg_wr && cfg_index == stvg_pkg::CFG_SEGMENT_COUNT) begin
				segment_count_q <= cfg_data;
				tgt_seg_q       <= 1'b1;
			end
			if (div_done) begin
				if (tgt_seg_q) begin
					recip_theta_q <= div_quotient;
				end else begin
					recip_phi_q <= div_quotient;
				end
			end
		end
	end

	stvg_recip_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.divisor (div_divisor),
		.busy    (div_busy),
		.done    (div_done),
		.quotient(div_quotient)
	);

	stvg_tile_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.tile_req (tile_req),
		.hold     (div_busy),
		.cfg      (cfg),
		.vtx_valid(vtx_valid),
		.vtx_ready(vtx_ready),
		.vtx      (vtx)
	);

	stvg_vertex_pipe #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
	) u_pipe (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.req_valid(vtx_valid),
		.req_ready(vtx_ready),
		.req      (vtx),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.vertex   (vertex)
	);

	a_write_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> !cfg_ready)
		else $error("count write did not start the reciprocal divider");

	a_hold_during_div: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_ready |-> in_stall)
		else $error("request taken while the reciprocal is stale");

endmodule

[tb/sphere_tile_vertex_generator_tb.sv]
// Self-checking testbench for the sphere tile vertex generator.
`timescale 1ns / 1ps
module sphere_tile_vertex_generator_tb;
	import stvg_pkg::*;

	localparam int DEPTH = SINE_TABLE_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 400;
	localparam logic [CFG_IDX_W-1:0] CFG_NO_SUCH_REG = 8'hFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CNT_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	tile_t tile_req = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	vertex_t vertex;

	sphere_tile_vertex_generator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.tile_req  (tile_req),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.vertex    (vertex)
	);

	int unsigned sine_tab [0:DEPTH];
	logic [CNT_W-1:0] ring_cfg = MIN_RINGS;
	logic [CNT_W-1:0] seg_cfg = MIN_SEGMENTS;

	tile_t pending_tiles [$];
	vertex_t vertex_q [$];
	int tiles_queued = 0;
	int tiles_sent = 0;
	int errors = 0;
	int cycles = 0;
	int hold_left = 0;
	logic hold_done = 1'b0;
	logic calm;

	assign calm = (tiles_sent >= 140) && (tiles_sent < 180);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic int unsigned clamp_count(logic [CNT_W-1:0] v, int unsigned lo);
		int unsigned c;
		c = 32'(v);
		if (c < lo) c = lo;
		if (c > MAX_DIVISIONS) c = MAX_DIVISIONS;
		return c;
	endfunction

	function automatic int quarter_sine(int unsigned r);
		int unsigned idx;
		idx = (r * DEPTH + 8192) >> 14;
		if (idx > DEPTH) idx = DEPTH;
		return int'(sine_tab[idx]);
	endfunction

	function automatic int sine_of(logic [ANGLE_W-1:0] a);
		int unsigned r;
		r = 32'(a[13:0]);
		case (a[15:14])
			2'd0: return quarter_sine(r);
			2'd1: return quarter_sine(16384 - r);
			2'd2: return -quarter_sine(r);
			default: return -quarter_sine(16384 - r);
		endcase
	endfunction

	// Q30 product to Q15, round half up; the shift of 16 folds in the radius 0.5
	function automatic longint q15_round(longint p);
		longint b;
		b = p + 32768 + (longint'(1) << 40);
		return (b >>> 16) - (longint'(1) << 24);
	endfunction

	function automatic vertex_t make_vertex(logic [ANGLE_W-1:0] phi,
		logic [ANGLE_W-1:0] theta, logic last);
		int sp, cp, st, ct;
		longint x, y, z;
		vertex_t v;
		sp = sine_of(phi);
		cp = sine_of(ANGLE_W'(phi + QUARTER_TURN));
		st = sine_of(theta);
		ct = sine_of(ANGLE_W'(theta + QUARTER_TURN));
		x = q15_round(longint'(sp) * st);
		y = q15_round(longint'(cp) * 32768);
		z = q15_round(longint'(sp) * ct);
		v.pos_x = COORD_W'(x);
		v.pos_y = COORD_W'(y);
		v.pos_z = COORD_W'(z);
		v.norm_x = COORD_W'(x);
		v.norm_y = COORD_W'(y);
		v.norm_z = COORD_W'(z);
		v.last_vertex = last;
		return v;
	endfunction

	task automatic push_tile_vertices(tile_t t);
		int unsigned rings, segs, i, j, phi_t, phi_b, th_l, th_r;
		rings = clamp_count(ring_cfg, MIN_RINGS);
		segs = clamp_count(seg_cfg, MIN_SEGMENTS);
		i = 32'(t.ring_index);
		j = 32'(t.segment_index);
		if (i > rings - 1) i = rings - 1;
		if (j > segs - 1) j = segs - 1;
		phi_t = (i * 65536 + rings) / (2 * rings);
		phi_b = ((i + 1) * 65536 + rings) / (2 * rings);
		// the last slice wraps to zero
		th_l = ((j * 131072 + segs) / (2 * segs)) & 32'hFFFF;
		th_r = (((j + 1) * 131072 + segs) / (2 * segs)) & 32'hFFFF;
		// TL, BL, BR, TR, TL, BR
		vertex_q = {vertex_q, make_vertex(ANGLE_W'(phi_t), ANGLE_W'(th_l), 1'b0)};
		vertex_q = {vertex_q, make_vertex(ANGLE_W'(phi_b), ANGLE_W'(th_l), 1'b0)};
		vertex_q = {vertex_q, make_vertex(ANGLE_W'(phi_b), ANGLE_W'(th_r), 1'b0)};
		vertex_q = {vertex_q, make_vertex(ANGLE_W'(phi_t), ANGLE_W'(th_r), 1'b0)};
		vertex_q = {vertex_q, make_vertex(ANGLE_W'(phi_t), ANGLE_W'(th_l), 1'b0)};
		vertex_q = {vertex_q, make_vertex(ANGLE_W'(phi_b), ANGLE_W'(th_r), 1'b1)};
	endtask

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				push_tile_vertices(tile_req);
				tiles_sent <= tiles_sent + 1;
			end
			if (!in_valid || !in_stall) begin
				if (pending_tiles.size() != 0 && (calm || $urandom_range(99) >= 13)) begin
					in_valid <= 1'b1;
					tile_req <= pending_tiles.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall: random, plus one long hold-off while requests are waiting
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (!hold_done && tiles_sent >= 80 && pending_tiles.size() > 8) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < 13);
		end
	end

	// vertex monitor
	always @(posedge clk) begin
		vertex_t exp_v;
		if (arst_n && out_valid && !out_stall) begin
			if (vertex_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected vertex x=%0d y=%0d z=%0d last=%0b",
						vertex.pos_x, vertex.pos_y, vertex.pos_z, vertex.last_vertex);
			end else begin
				exp_v = vertex_q.pop_front();
				if (vertex.pos_x !== exp_v.pos_x || vertex.pos_y !== exp_v.pos_y ||
					vertex.pos_z !== exp_v.pos_z || vertex.norm_x !== exp_v.norm_x ||
					vertex.norm_y !== exp_v.norm_y || vertex.norm_z !== exp_v.norm_z ||
					vertex.last_vertex !== exp_v.last_vertex) begin
					errors++;
					if (errors <= 10) begin
						$display("vertex mismatch, expected pos %0d %0d %0d norm %0d %0d %0d last %0b",
							exp_v.pos_x, exp_v.pos_y, exp_v.pos_z, exp_v.norm_x,
							exp_v.norm_y, exp_v.norm_z, exp_v.last_vertex);
						$display("                 actual   pos %0d %0d %0d norm %0d %0d %0d last %0b",
							vertex.pos_x, vertex.pos_y, vertex.pos_z, vertex.norm_x,
							vertex.norm_y, vertex.norm_z, vertex.last_vertex);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("sphere_tile_vertex_generator_tb failed");
			$finish;
		end
	end

	task automatic queue_tile(int unsigned ring, int unsigned seg);
		tile_t t;
		t.ring_index = IDX_W'(ring);
		t.segment_index = IDX_W'(seg);
		pending_tiles = {pending_tiles, t};
		tiles_queued++;
	endtask

	// hold until every request is taken and every vertex has come back
	task automatic drain();
		while (tiles_sent != tiles_queued || vertex_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_RING_COUNT) ring_cfg = data;
		else if (idx == CFG_SEGMENT_COUNT) seg_cfg = data;
	endtask

	function automatic logic [CNT_W-1:0] pick_count();
		case ($urandom_range(3))
			0: return CNT_W'($urandom_range(0, 3));
			1: return CNT_W'($urandom_range(4, 16));
			2: return CNT_W'($urandom_range(17, 255));
			default: return CNT_W'(255);
		endcase
	endfunction

	initial begin
		longint unsigned x, sum, term, q15;
		int unsigned rings, segs;
		for (int k = 0; k <= DEPTH; k++) begin
			x = (longint'(k) * PI_Q30) / (2 * DEPTH);
			sum = x;
			term = x;
			for (int n = 1; n <= 7; n++) begin
				term = (term * x) >> 30;
				term = (term * x) >> 30;
				term = term / ((2 * n) * (2 * n + 1));
				if (n % 2 == 1) sum = sum - term;
				else sum = sum + term;
			end
			q15 = (sum + (64'd1 << 14)) >> 15;
			if (q15 > 32767) q15 = 32767;
			sine_tab[k] = int'(q15);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset counts: 2 rings, 3 segments; saturating indices
		@(negedge clk);
		queue_tile(0, 0);
		queue_tile(1, 2);
		queue_tile(255, 255);
		queue_tile(0, 3);
		drain();

		// counts below the floor
		write_reg(CFG_RING_COUNT, 8'd0);
		write_reg(CFG_SEGMENT_COUNT, 8'd0);
		@(negedge clk);
		queue_tile(1, 0);
		queue_tile(0, 2);
		drain();

		// largest counts, last slice wrap
		write_reg(CFG_RING_COUNT, 8'd255);
		write_reg(CFG_SEGMENT_COUNT, 8'd255);
		@(negedge clk);
		queue_tile(0, 0);
		queue_tile(254, 254);
		queue_tile(255, 255);
		queue_tile(127, 128);
		queue_tile(0, 127);
		queue_tile(200, 254);
		drain();

		// unknown register: counts stay
		write_reg(CFG_NO_SUCH_REG, 8'd0);
		@(negedge clk);
		queue_tile(1, 1);
		drain();

		write_reg(CFG_RING_COUNT, 8'd1);
		write_reg(CFG_SEGMENT_COUNT, 8'd2);
		@(negedge clk);
		queue_tile(0, 1);
		queue_tile(7, 9);
		drain();

		write_reg(CFG_RING_COUNT, 8'd3);
		write_reg(CFG_SEGMENT_COUNT, 8'd4);
		@(negedge clk);
		queue_tile(2, 3);
		queue_tile(1, 0);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			if ($urandom_range(3) == 0)
				write_reg(CFG_IDX_W'($urandom_range(2, 255)), CNT_W'($urandom));
			write_reg(CFG_RING_COUNT, pick_count());
			write_reg(CFG_SEGMENT_COUNT, pick_count());
			rings = clamp_count(ring_cfg, MIN_RINGS);
			segs = clamp_count(seg_cfg, MIN_SEGMENTS);
			@(negedge clk);
			for (int n = 0; n < 28; n++) begin
				// mostly in-range tiles, some out of range
				if ($urandom_range(99) < 80)
					queue_tile($urandom_range(rings - 1), $urandom_range(segs - 1));
				else
					queue_tile($urandom_range(255), $urandom_range(255));
			end
			drain();
		end

		repeat (30) @(posedge clk);
		if (errors == 0 && vertex_q.size() == 0) begin
			$display("sphere_tile_vertex_generator_tb passed");
		end else begin
			$display("sphere_tile_vertex_generator_tb failed");
		end
		$finish;
	end

endmodule

[files.f]
src/stvg_pkg.sv
src/stvg_recip_div.sv
src/stvg_sine_rom.sv
src/stvg_tile_seq.sv
src/stvg_vertex_pipe.sv
src/sphere_tile_vertex_generator.sv
tb/sphere_tile_vertex_generator_tb.sv
